@@ rtl/tmch_pkg.sv @@
package tmch_pkg;

    localparam int TILES_ACROSS  = 4;
    localparam int TILES_DOWN    = 12;
    localparam int MAX_TILE_SIDE = 64;

    localparam int PIX_W   = 8;
    localparam int SIDE_W  = 7;
    localparam int POS_W   = (MAX_TILE_SIDE > 1) ? $clog2(MAX_TILE_SIDE) : 1;
    localparam int TCOL_W  = (TILES_ACROSS > 1) ? $clog2(TILES_ACROSS) : 1;
    localparam int TROW_W  = (TILES_DOWN > 1) ? $clog2(TILES_DOWN) : 1;
    localparam int AREA_W  = $clog2(MAX_TILE_SIDE * MAX_TILE_SIDE + 1);
    localparam int SUM_W   = 20;
    localparam int DIV_CNT_W = $clog2(SUM_W + 1);

    localparam int NUM_CH     = 3;
    localparam int CH_W       = 2;
    localparam int NUM_BINS   = 5;
    localparam int BIN_W      = 3;
    localparam int LVL_DEPTH  = NUM_CH * NUM_BINS;
    localparam int LVL_AW     = $clog2(LVL_DEPTH);
    localparam int COUNT_W    = 6;
    localparam int COUNT_MAX  = 63;
    localparam int TIDX_W     = 6;

    localparam int LEVEL_1 = 51;
    localparam int LEVEL_2 = 102;
    localparam int LEVEL_3 = 153;
    localparam int LEVEL_4 = 204;
    localparam int MEAN_MAX = 255;

    localparam logic KIND_TILE = 1'b0;
    localparam logic KIND_HIST = 1'b1;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic REG_TILE_WIDTH  = 1'b0;
    localparam logic REG_TILE_HEIGHT = 1'b1;
    localparam logic [SIDE_W-1:0] SIDE_RESET = 7'd50;

    typedef struct packed {
        logic [PIX_W-1:0] red;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] blue;
        logic             frame_start;
    } pixel_t;

    typedef struct packed {
        logic              kind;
        logic [TIDX_W-1:0] tile_index;
        logic [PIX_W-1:0]  mean_red;
        logic [PIX_W-1:0]  mean_green;
        logic [PIX_W-1:0]  mean_blue;
        logic [CH_W-1:0]   channel;
        logic [BIN_W-1:0]  level_bin;
        logic [COUNT_W-1:0] bin_count;
        logic              last;
    } result_t;

    typedef struct packed {
        logic [SIDE_W-1:0] tile_w;
        logic [SIDE_W-1:0] tile_h;
        logic [AREA_W-1:0] area;
    } geom_t;

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
        logic [SIDE_W-1:0] r;
        if (v == '0)
            r = SIDE_W'(1);
        else if (int'(v) > MAX_TILE_SIDE)
            r = SIDE_W'(MAX_TILE_SIDE);
        else
            r = v;
        return r;
    endfunction

    function automatic logic [BIN_W-1:0] level_of(input logic [PIX_W-1:0] v);
        logic [BIN_W-1:0] b;
        if (int'(v) < LEVEL_1)
            b = BIN_W'(0);
        else if (int'(v) < LEVEL_2)
            b = BIN_W'(1);
        else if (int'(v) < LEVEL_3)
            b = BIN_W'(2);
        else if (int'(v) < LEVEL_4)
            b = BIN_W'(3);
        else
            b = BIN_W'(4);
        return b;
    endfunction

endpackage

@@ rtl/tmch_ram.sv @@
module tmch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/tmch_cfg.sv @@
module tmch_cfg import tmch_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output geom_t             geom,
    output logic              restart
);

    logic [SIDE_W-1:0] tile_w_reg;
    logic [SIDE_W-1:0] tile_w_next;
    logic [SIDE_W-1:0] tile_h_reg;
    logic [SIDE_W-1:0] tile_h_next;
    logic              wr_en;
    logic [SIDE_W-1:0] w_clamped;
    logic [SIDE_W-1:0] h_clamped;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign restart = wr_en;

    always_comb
    begin
        tile_w_next = tile_w_reg;
        tile_h_next = tile_h_reg;
        prdata      = '0;
        unique case (paddr[2])
            REG_TILE_WIDTH:
            begin
                prdata = APB_DW'(tile_w_reg);
                if (wr_en)
                    tile_w_next = pwdata[SIDE_W-1:0];
            end
            REG_TILE_HEIGHT:
            begin
                prdata = APB_DW'(tile_h_reg);
                if (wr_en)
                    tile_h_next = pwdata[SIDE_W-1:0];
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tile_w_reg <= SIDE_RESET;
            tile_h_reg <= SIDE_RESET;
        end
        else
        begin
            tile_w_reg <= tile_w_next;
            tile_h_reg <= tile_h_next;
        end
    end

    assign w_clamped   = clamp_side(tile_w_reg);
    assign h_clamped   = clamp_side(tile_h_reg);
    assign geom.tile_w = w_clamped;
    assign geom.tile_h = h_clamped;
    assign geom.area   = AREA_W'(w_clamped) * AREA_W'(h_clamped);

endmodule

@@ rtl/tmch_div.sv @@
module tmch_div import tmch_pkg::*; (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [NUM_CH-1:0][SUM_W-1:0] dividend,
    input  logic [AREA_W-1:0]            divisor,
    output logic                         done,
    output logic [NUM_CH-1:0][SUM_W-1:0] quotient
);

    logic                         busy_reg;
    logic                         busy_next;
    logic                         done_reg;
    logic                         done_next;
    logic [DIV_CNT_W-1:0]         cnt_reg;
    logic [DIV_CNT_W-1:0]         cnt_next;
    logic [AREA_W-1:0]            dvs_reg;
    logic [AREA_W-1:0]            dvs_next;
    logic [NUM_CH-1:0][SUM_W-1:0] num_reg;
    logic [NUM_CH-1:0][SUM_W-1:0] num_next;
    logic [NUM_CH-1:0][AREA_W-1:0] rem_reg;
    logic [NUM_CH-1:0][AREA_W-1:0] rem_next;
    logic [AREA_W:0]              trial [NUM_CH];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvs_next  = dvs_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        for (int c = 0; c < NUM_CH; c++)
        begin
            trial[c] = {rem_reg[c], num_reg[c][SUM_W-1]};
        end
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvs_next  = divisor;
            num_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                if (trial[c] >= {1'b0, dvs_reg})
                begin
                    rem_next[c] = AREA_W'(trial[c] - {1'b0, dvs_reg});
                    num_next[c] = {num_reg[c][SUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next[c] = trial[c][AREA_W-1:0];
                    num_next[c] = {num_reg[c][SUM_W-2:0], 1'b0};
                end
            end
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvs_reg <= dvs_next;
        num_reg <= num_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

@@ rtl/tile_mean_color_histogram_core.sv @@
// A pixel that does not end a tile is summed in S_ACC; then S_IDLE takes the next.
// Last pixel of a tile: the divider runs, the tile result is loaded into the output
// register once it is free, then each channel's bin is read and written back.
// Last pixel of a frame: after that, the bin counts are read and sent out one by one.
// The pace is set by the 20-step shared divider and the single-port bin memory.
// Reset clears position, sum and bin valid flags; geometry returns to 50 x 50.
module tile_mean_color_histogram_core import tmch_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pixel_valid,
    output logic              pixel_stall,
    input  pixel_t            pixel,
    output logic              result_valid,
    input  logic              result_stall,
    output result_t           result,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_DIV,
        S_TILE_OUT,
        S_HIST_RD,
        S_HIST_WR,
        S_DUMP_RD,
        S_DUMP_OUT
    } state_t;

    localparam int SUMS_W = NUM_CH * SUM_W;

    geom_t geom;
    logic  cfg_restart;

    state_t                 state_reg, state_next;
    logic [POS_W-1:0]       cit_reg, cit_next;
    logic [TCOL_W-1:0]      tcol_reg, tcol_next;
    logic [POS_W-1:0]       rit_reg, rit_next;
    logic [TROW_W-1:0]      trow_reg, trow_next;
    pixel_t                 px_reg, px_next;
    logic [TILES_ACROSS-1:0] sum_vld_reg, sum_vld_next;
    logic [LVL_DEPTH-1:0]   lvl_vld_reg, lvl_vld_next;
    logic [TIDX_W-1:0]      tidx_reg, tidx_next;
    logic [NUM_CH-1:0][PIX_W-1:0] mean_reg, mean_next;
    logic [NUM_CH-1:0][BIN_W-1:0] bin_reg, bin_next;
    logic                   frame_end_reg, frame_end_next;
    logic [CH_W-1:0]        ch_reg, ch_next;
    logic [BIN_W-1:0]       dbin_reg, dbin_next;
    logic                   res_valid_reg, res_valid_next;
    result_t                res_reg, res_next;

    logic                   sum_re;
    logic [TCOL_W-1:0]      sum_raddr;
    logic                   sum_we;
    logic [SUMS_W-1:0]      sum_wdata;
    logic [SUMS_W-1:0]      sum_rdata;

    logic                   lvl_re;
    logic                   lvl_we;
    logic [LVL_AW-1:0]      lvl_addr;
    logic [COUNT_W-1:0]     lvl_wdata;
    logic [COUNT_W-1:0]     lvl_rdata;
    logic [COUNT_W-1:0]     lvl_cur;
    logic [BIN_W-1:0]       bin_sel;

    logic                         div_start;
    logic                         div_done;
    logic [NUM_CH-1:0][SUM_W-1:0] div_dividend;
    logic [NUM_CH-1:0][SUM_W-1:0] div_quot;
    logic [NUM_CH-1:0][PIX_W-1:0] quot_clamped;

    logic [NUM_CH-1:0][PIX_W-1:0] px_ch;
    logic [NUM_CH-1:0][SUM_W-1:0] acc_sum;
    logic                   col_last, row_last, tcol_last, trow_last, tile_end;
    logic                   accept, out_free, res_load;
    result_t                res_data;

    tmch_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .geom    (geom),
        .restart (cfg_restart)
    );

    tmch_ram #(
        .WIDTH (SUMS_W),
        .DEPTH (TILES_ACROSS)
    ) u_sum_ram (
        .clk   (clk),
        .we    (sum_we),
        .waddr (tcol_reg),
        .wdata (sum_wdata),
        .re    (sum_re),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    tmch_ram #(
        .WIDTH (COUNT_W),
        .DEPTH (LVL_DEPTH)
    ) u_lvl_ram (
        .clk   (clk),
        .we    (lvl_we),
        .waddr (lvl_addr),
        .wdata (lvl_wdata),
        .re    (lvl_re),
        .raddr (lvl_addr),
        .rdata (lvl_rdata)
    );

    tmch_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (geom.area),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign pixel_stall  = (state_reg != S_IDLE);
    assign accept       = pixel_valid && (state_reg == S_IDLE);
    assign out_free     = !res_valid_reg || !result_stall;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    assign px_ch[0] = px_reg.red;
    assign px_ch[1] = px_reg.green;
    assign px_ch[2] = px_reg.blue;

    assign col_last  = (SIDE_W'(cit_reg) == geom.tile_w - SIDE_W'(1));
    assign row_last  = (SIDE_W'(rit_reg) == geom.tile_h - SIDE_W'(1));
    assign tcol_last = (tcol_reg == TCOL_W'(TILES_ACROSS - 1));
    assign trow_last = (trow_reg == TROW_W'(TILES_DOWN - 1));
    assign tile_end  = col_last && row_last;

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            acc_sum[c] = (sum_vld_reg[tcol_reg] ? sum_rdata[c*SUM_W +: SUM_W] : '0)
                       + SUM_W'(px_ch[c]);
            div_dividend[c] = acc_sum[c];
            quot_clamped[c] = (|div_quot[c][SUM_W-1:PIX_W]) ? PIX_W'(MEAN_MAX)
                                                             : div_quot[c][PIX_W-1:0];
        end
    end

    assign sum_wdata = {acc_sum[2], acc_sum[1], acc_sum[0]};

    assign bin_sel  = (state_reg == S_DUMP_RD || state_reg == S_DUMP_OUT) ? dbin_reg
                                                                          : bin_reg[ch_reg];
    assign lvl_addr = LVL_AW'(ch_reg * NUM_BINS + bin_sel);
    assign lvl_cur  = lvl_vld_reg[lvl_addr] ? lvl_rdata : '0;
    assign lvl_wdata = (lvl_cur == COUNT_W'(COUNT_MAX)) ? lvl_cur : lvl_cur + COUNT_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        cit_next       = cit_reg;
        tcol_next      = tcol_reg;
        rit_next       = rit_reg;
        trow_next      = trow_reg;
        px_next        = px_reg;
        sum_vld_next   = sum_vld_reg;
        lvl_vld_next   = lvl_vld_reg;
        tidx_next      = tidx_reg;
        mean_next      = mean_reg;
        bin_next       = bin_reg;
        frame_end_next = frame_end_reg;
        ch_next        = ch_reg;
        dbin_next      = dbin_reg;
        sum_re         = 1'b0;
        sum_raddr      = tcol_reg;
        sum_we         = 1'b0;
        lvl_re         = 1'b0;
        lvl_we         = 1'b0;
        div_start      = 1'b0;
        res_load       = 1'b0;
        res_data       = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    px_next = pixel;
                    sum_re  = 1'b1;
                    if (pixel.frame_start)
                    begin
                        cit_next     = '0;
                        tcol_next    = '0;
                        rit_next     = '0;
                        trow_next    = '0;
                        sum_vld_next = '0;
                        lvl_vld_next = '0;
                        sum_raddr    = '0;
                    end
                    state_next = S_ACC;
                end
            end
            S_ACC:
            begin
                frame_end_next = tile_end && tcol_last && trow_last;
                if (tile_end)
                begin
                    sum_vld_next[tcol_reg] = 1'b0;
                    div_start  = 1'b1;
                    tidx_next  = TIDX_W'(int'(trow_reg) * TILES_ACROSS + int'(tcol_reg));
                    state_next = S_DIV;
                end
                else
                begin
                    sum_we = 1'b1;
                    sum_vld_next[tcol_reg] = 1'b1;
                    state_next = S_IDLE;
                end
                // advance raster position
                if (col_last)
                begin
                    cit_next = '0;
                    if (tcol_last)
                    begin
                        tcol_next = '0;
                        if (row_last)
                        begin
                            rit_next  = '0;
                            trow_next = trow_last ? '0 : trow_reg + TROW_W'(1);
                        end
                        else
                        begin
                            rit_next = rit_reg + POS_W'(1);
                        end
                    end
                    else
                    begin
                        tcol_next = tcol_reg + TCOL_W'(1);
                    end
                end
                else
                begin
                    cit_next = cit_reg + POS_W'(1);
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    for (int c = 0; c < NUM_CH; c++)
                    begin
                        mean_next[c] = quot_clamped[c];
                        bin_next[c]  = level_of(quot_clamped[c]);
                    end
                    state_next = S_TILE_OUT;
                end
            end
            S_TILE_OUT:
            begin
                if (out_free)
                begin
                    res_load            = 1'b1;
                    res_data.kind       = KIND_TILE;
                    res_data.tile_index = tidx_reg;
                    res_data.mean_red   = mean_reg[0];
                    res_data.mean_green = mean_reg[1];
                    res_data.mean_blue  = mean_reg[2];
                    ch_next    = '0;
                    state_next = S_HIST_RD;
                end
            end
            S_HIST_RD:
            begin
                lvl_re     = 1'b1;
                state_next = S_HIST_WR;
            end
            S_HIST_WR:
            begin
                lvl_we = 1'b1;
                lvl_vld_next[lvl_addr] = 1'b1;
                if (ch_reg == CH_W'(NUM_CH - 1))
                begin
                    ch_next   = '0;
                    dbin_next = '0;
                    state_next = frame_end_reg ? S_DUMP_RD : S_IDLE;
                end
                else
                begin
                    ch_next    = ch_reg + CH_W'(1);
                    state_next = S_HIST_RD;
                end
            end
            S_DUMP_RD:
            begin
                lvl_re     = 1'b1;
                state_next = S_DUMP_OUT;
            end
            S_DUMP_OUT:
            begin
                if (out_free)
                begin
                    res_load           = 1'b1;
                    res_data.kind      = KIND_HIST;
                    res_data.channel   = ch_reg;
                    res_data.level_bin = dbin_reg;
                    res_data.bin_count = lvl_cur;
                    res_data.last      = (ch_reg == CH_W'(NUM_CH - 1))
                                      && (dbin_reg == BIN_W'(NUM_BINS - 1));
                    if (res_data.last)
                    begin
                        cit_next     = '0;
                        tcol_next    = '0;
                        rit_next     = '0;
                        trow_next    = '0;
                        sum_vld_next = '0;
                        lvl_vld_next = '0;
                        state_next   = S_IDLE;
                    end
                    else
                    begin
                        if (dbin_reg == BIN_W'(NUM_BINS - 1))
                        begin
                            dbin_next = '0;
                            ch_next   = ch_reg + CH_W'(1);
                        end
                        else
                        begin
                            dbin_next = dbin_reg + BIN_W'(1);
                        end
                        state_next = S_DUMP_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // restart frame on a register write
        if (cfg_restart)
        begin
            cit_next     = '0;
            tcol_next    = '0;
            rit_next     = '0;
            trow_next    = '0;
            sum_vld_next = '0;
            lvl_vld_next = '0;
        end

        res_next = res_reg;
        if (res_load)
        begin
            res_valid_next = 1'b1;
            res_next       = res_data;
        end
        else if (!result_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cit_reg       <= '0;
            tcol_reg      <= '0;
            rit_reg       <= '0;
            trow_reg      <= '0;
            sum_vld_reg   <= '0;
            lvl_vld_reg   <= '0;
            frame_end_reg <= 1'b0;
            ch_reg        <= '0;
            dbin_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cit_reg       <= cit_next;
            tcol_reg      <= tcol_next;
            rit_reg       <= rit_next;
            trow_reg      <= trow_next;
            sum_vld_reg   <= sum_vld_next;
            lvl_vld_reg   <= lvl_vld_next;
            frame_end_reg <= frame_end_next;
            ch_reg        <= ch_next;
            dbin_reg      <= dbin_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg   <= px_next;
        tidx_reg <= tidx_next;
        mean_reg <= mean_next;
        bin_reg  <= bin_next;
        res_reg  <= res_next;
    end

endmodule

@@ rtl/tmch_checker.sv @@
module tmch_checker import tmch_pkg::*; (
    input logic    clk,
    input logic    rst_n,
    input logic    pixel_valid,
    input logic    pixel_stall,
    input logic    result_valid,
    input logic    result_stall,
    input result_t result
);

    // hold a stalled transfer
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    a_pixel_busy: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_valid && !pixel_stall |=> pixel_stall)
        else $error("pixel taken while previous one in progress");

    a_last_shape: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.last |->
            result.kind == KIND_HIST
            && result.channel == CH_W'(NUM_CH - 1)
            && result.level_bin == BIN_W'(NUM_BINS - 1))
        else $error("last flag on wrong result");

    a_tile_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind == KIND_TILE |->
            result.channel == '0 && result.level_bin == '0
            && result.bin_count == '0 && !result.last)
        else $error("tile result carries histogram fields");

    a_hist_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind == KIND_HIST |->
            result.tile_index == '0 && result.mean_red == '0
            && result.mean_green == '0 && result.mean_blue == '0)
        else $error("histogram result carries tile fields");

endmodule

bind tile_mean_color_histogram_core tmch_checker u_tmch_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
